FILE: sv/awt_pkg.sv
// Shared types, widths, register codes and reset values of the ADC window temperature unit.
`default_nettype none
package awt_pkg;

	localparam int WINDOW_DEF      = 10;
	localparam int SAMPLE_BITS_DEF = 12;

	localparam int SMP_W    = 12;
	localparam int CNT_W    = 7;
	localparam int SUM_W    = 18;
	localparam int TEMP_W   = 21;
	localparam int V25_W    = 12;
	localparam int REF_W    = 13;
	localparam int SLOPE_W  = 10;
	localparam int BASE_W   = 15;
	localparam int MV_W     = 13;
	localparam int DIFF_W   = 14;
	localparam int PROD_W   = SMP_W + REF_W;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_V25   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REF   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOPE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 3'd3;

	localparam logic [V25_W-1:0]          V25_RST   = 12'd1430;
	localparam logic [REF_W-1:0]          REF_RST   = 13'd3300;
	localparam logic [SLOPE_W-1:0]        SLOPE_RST = 10'd435;
	localparam logic signed [BASE_W-1:0]  BASE_RST  = 15'sd2500;

	localparam int SCALE_K    = 10000;
	localparam int TEMP_LIMIT = 600000;

	// serial divider: dividend wide enough for |diff| * 10000
	localparam int DVD_W  = 27;
	localparam int DVS_W  = 10;
	localparam int STEP_W = 5;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] cnt;
	} awt_entry_t;

	typedef struct packed {
		logic [V25_W-1:0]         v25;
		logic [REF_W-1:0]         ref_mv;
		logic [SLOPE_W-1:0]       slope;
		logic signed [BASE_W-1:0] base;
	} awt_cfg_t;

	typedef struct packed {
		logic              start;
		logic [DVD_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} awt_div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} awt_div_rsp_t;

	typedef enum logic {
		F_IDLE,
		F_UPD
	} awt_front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV_MEAN,
		B_MUL,
		B_SCALE,
		B_START_T,
		B_DIV_TEMP,
		B_DONE
	} awt_back_state_t;

endpackage
`default_nettype wire

FILE: sv/adc_window_average_to_temperature_unit.sv
// Top level of the ADC window average to temperature unit: config registers and wiring.
// The back end takes a new queue entry only after the last result is loaded for output;
//   its shared serial divider works out 18 quotient bits for the mean, 27 for the temperature.
// The front end takes a new sample only in its idle state, while the queue has room.
// Reset (arst_n low, asynchronous) clears control state and loads register defaults;
//   the sample ring is not cleared, the fill count keeps unwritten entries unread.
`default_nettype none
module adc_window_average_to_temperature_unit #(
	parameter int WINDOW      = awt_pkg::WINDOW_DEF,
	parameter int SAMPLE_BITS = awt_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [15:0]                  s_tdata,   // [11:0] adc_sample
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [39:0]                       m_tdata,   // [20:0] temperature_centideg,
	                                                     // [32:21] average_code,
	                                                     // [39:33] samples_in_window
	input  wire logic                         cfg_we,
	input  wire logic [awt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [awt_pkg::CFG_DAT_W-1:0] cfg_wdata
);
	import awt_pkg::*;

	awt_cfg_t     cfg_q;
	awt_entry_t   push_data, head;
	awt_div_req_t div_req;
	awt_div_rsp_t div_rsp;
	logic         push, pop, fifo_full, fifo_empty;
	logic [TEMP_W-1:0] temperature;
	logic [SMP_W-1:0]  average;
	logic [CNT_W-1:0]  samples;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.v25    <= V25_RST;
			cfg_q.ref_mv <= REF_RST;
			cfg_q.slope  <= SLOPE_RST;
			cfg_q.base   <= BASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_V25:   cfg_q.v25    <= cfg_wdata[V25_W-1:0];
				CFG_REF:   cfg_q.ref_mv <= cfg_wdata[REF_W-1:0];
				CFG_SLOPE: cfg_q.slope  <= cfg_wdata[SLOPE_W-1:0];
				CFG_BASE:  cfg_q.base   <= $signed(cfg_wdata[BASE_W-1:0]);
				default: ;
			endcase
		end
	end

	awt_front #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.sample    (s_tdata[SMP_W-1:0]),
		.fifo_full (fifo_full),
		.push      (push),
		.push_data (push_data)
	);

	awt_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (head),
		.full      (fifo_full),
		.empty     (fifo_empty)
	);

	awt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	awt_back #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.fifo_empty  (fifo_empty),
		.pop         (pop),
		.div_req     (div_req),
		.div_rsp     (div_rsp),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.temperature (temperature),
		.average     (average),
		.samples     (samples)
	);

	assign m_tdata = {samples, average, temperature};

endmodule
`default_nettype wire

FILE: sv/awt_front.sv
// Front end: accepts samples, updates the sample ring, fill count and running sum.
`default_nettype none
module awt_front #(
	parameter int WINDOW      = awt_pkg::WINDOW_DEF,
	parameter int SAMPLE_BITS = awt_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [awt_pkg::SMP_W-1:0] sample,
	input  wire logic                     fifo_full,
	output logic                          push,
	output awt_pkg::awt_entry_t           push_data
);
	import awt_pkg::*;

	localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [SMP_W-1:0] SMP_MASK =
		(SAMPLE_BITS >= SMP_W) ? {SMP_W{1'b1}} : SMP_W'((1 << SAMPLE_BITS) - 1);

	awt_front_state_t state_q, state_d;

	logic [SMP_W-1:0] ring [WINDOW];
	logic [SMP_W-1:0] old_s1, smp_s1;
	logic             evict_s1;
	logic [PTR_W-1:0] ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q, sum_next;
	logic [SMP_W-1:0] smp;
	logic             acc;

	assign smp = sample & SMP_MASK;
	assign acc = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (acc) state_d = F_UPD;
			F_UPD:  state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		push     = 1'b0;
		unique case (state_q)
			F_IDLE: s_tready = !fifo_full;
			F_UPD:  push = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		sum_next = sum_q - (evict_s1 ? SUM_W'(old_s1) : '0) + SUM_W'(smp_s1);
		push_data.sum = sum_next;
		push_data.cnt = cnt_q;
	end

	// read the evicted entry before it is overwritten
	always_ff @(posedge clk) begin
		if (acc) begin
			old_s1    <= ring[ptr_q];
			ring[ptr_q] <= smp;
			smp_s1    <= smp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			ptr_q    <= '0;
			cnt_q    <= '0;
			sum_q    <= '0;
			evict_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				ptr_q    <= (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
				evict_s1 <= (cnt_q >= CNT_W'(WINDOW));
				if (cnt_q < CNT_W'(WINDOW)) cnt_q <= cnt_q + 1'b1;
			end
			if (push) sum_q <= sum_next;
		end
	end

endmodule
`default_nettype wire

FILE: sv/awt_fifo.sv
// Short queue between front end and back end.
`default_nettype none
module awt_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire awt_pkg::awt_entry_t push_data,
	input  wire logic                pop,
	output awt_pkg::awt_entry_t      pop_data,
	output logic                     full,
	output logic                     empty
);
	import awt_pkg::*;

	awt_entry_t            mem [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q, rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/awt_div.sv
// Restoring serial divider, one quotient bit per cycle, shared by mean and temperature.
`default_nettype none
module awt_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire awt_pkg::awt_div_req_t req,
	output awt_pkg::awt_div_rsp_t      rsp
);
	import awt_pkg::*;

	logic [DVS_W-1:0]  rem_q, dvs_q;
	logic [DVD_W-1:0]  quo_q;
	logic [STEP_W-1:0] left_q;
	logic              busy_q, done_q;
	logic [DVS_W:0]    shifted;
	logic [DVS_W+1:0]  trial;
	logic              ge;

	always_comb begin
		shifted = {rem_q, quo_q[DVD_W-1]};
		trial   = {1'b0, shifted} - {2'b00, dvs_q};
		ge      = !trial[DVS_W+1];
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
		end else begin
			done_q <= busy_q && (left_q == STEP_W'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				left_q <= req.steps;
			end else if (busy_q) begin
				left_q <= left_q - 1'b1;
				if (left_q == STEP_W'(1)) busy_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/awt_back.sv
// Back end: mean, millivolt scaling, temperature division, saturation and output register.
`default_nettype none
module awt_back #(
	parameter int SAMPLE_BITS = awt_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire awt_pkg::awt_cfg_t          cfg,
	input  wire awt_pkg::awt_entry_t        head,
	input  wire logic                       fifo_empty,
	output logic                            pop,
	output awt_pkg::awt_div_req_t           div_req,
	input  wire awt_pkg::awt_div_rsp_t      div_rsp,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [awt_pkg::TEMP_W-1:0]      temperature,
	output logic [awt_pkg::SMP_W-1:0]       average,
	output logic [awt_pkg::CNT_W-1:0]       samples
);
	import awt_pkg::*;

	localparam logic signed [DVD_W+1:0] LIM_POS = (DVD_W + 2)'(TEMP_LIMIT);
	localparam logic signed [DVD_W+1:0] LIM_NEG = -(DVD_W + 2)'(TEMP_LIMIT);

	awt_back_state_t state_q, state_d;

	logic [CNT_W-1:0]         cnt_q;
	logic [SMP_W-1:0]         mean_q;
	logic [PROD_W-1:0]        prod_q;
	logic [DVD_W-1:0]         scaled_q;
	logic                     neg_q;
	logic signed [DVD_W+1:0]  t_q;
	logic                     out_free, load_out;

	logic [PROD_W-1:0]        mv_full;
	logic [MV_W-1:0]          mv;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        mag;
	logic [SLOPE_W-1:0]       slope_eff;
	logic signed [DVD_W:0]    q_sgn;
	logic signed [DVD_W+1:0]  t_sum;
	logic [TEMP_W-1:0]        t_sat;

	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:     if (!fifo_empty) state_d = B_DIV_MEAN;
			B_DIV_MEAN: if (div_rsp.done) state_d = B_MUL;
			B_MUL:      state_d = B_SCALE;
			B_SCALE:    state_d = B_START_T;
			B_START_T:  state_d = B_DIV_TEMP;
			B_DIV_TEMP: if (div_rsp.done) state_d = B_DONE;
			B_DONE:     if (out_free) state_d = B_IDLE;
			default:    state_d = B_IDLE;
		endcase
	end

	always_comb begin
		slope_eff = (cfg.slope == '0) ? SLOPE_W'(1) : cfg.slope;
		pop       = 1'b0;
		load_out  = 1'b0;
		div_req   = '0;
		unique case (state_q)
			B_IDLE: begin
				if (!fifo_empty) begin
					pop              = 1'b1;
					div_req.start    = 1'b1;
					div_req.dividend = {head.sum, {(DVD_W - SUM_W){1'b0}}};
					div_req.divisor  = DVS_W'(head.cnt);
					div_req.steps    = STEP_W'(SUM_W);
				end
			end
			B_START_T: begin
				div_req.start    = 1'b1;
				div_req.dividend = scaled_q;
				div_req.divisor  = DVS_W'(slope_eff);
				div_req.steps    = STEP_W'(DVD_W);
			end
			B_DONE: load_out = out_free;
			default: ;
		endcase
	end

	always_comb begin
		mv_full = prod_q >> SAMPLE_BITS;
		mv      = mv_full[MV_W-1:0];
		diff    = $signed({2'b00, cfg.v25}) - $signed({1'b0, mv});
		mag     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		q_sgn   = $signed({1'b0, div_rsp.quotient});
		if (neg_q) q_sgn = -q_sgn;
		t_sum   = (DVD_W + 2)'(q_sgn) + (DVD_W + 2)'(cfg.base);
		if (t_q > LIM_POS)
			t_sat = TEMP_W'(LIM_POS);
		else if (t_q < LIM_NEG)
			t_sat = TEMP_W'(LIM_NEG);
		else
			t_sat = TEMP_W'(t_q);
	end

	always_ff @(posedge clk) begin
		if (pop) cnt_q <= head.cnt;
		if (state_q == B_DIV_MEAN && div_rsp.done) mean_q <= div_rsp.quotient[SMP_W-1:0];
		if (state_q == B_MUL) prod_q <= PROD_W'(mean_q) * PROD_W'(cfg.ref_mv);
		if (state_q == B_SCALE) begin
			scaled_q <= DVD_W'(mag) * DVD_W'(SCALE_K);
			neg_q    <= diff[DIFF_W-1];
		end
		if (state_q == B_DIV_TEMP && div_rsp.done) t_q <= t_sum;
		if (load_out) begin
			temperature <= t_sat;
			average     <= mean_q;
			samples     <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
		end
	end

endmodule
`default_nettype wire

FILE: verif/adc_window_average_to_temperature_unit_test.sv
// Self-checking testbench of the ADC window average to temperature unit.
`timescale 1ns / 1ps
module adc_window_average_to_temperature_unit_test;
	import awt_pkg::*;

	localparam int RANDOM_ITEMS  = 2000;
	localparam int BLOCK_ITEMS   = 200;
	localparam int MAX_GAP       = 14;
	localparam int SETTLE_CYCLES = 60;
	localparam int CYCLE_LIMIT   = 1000000;

	// same layout as m_tdata: count on top, temperature in the low bits
	typedef struct packed {
		logic [CNT_W-1:0]         cnt;
		logic [SMP_W-1:0]         avg;
		logic signed [TEMP_W-1:0] temp;
	} reading_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [15:0]          s_tdata;   // [11:0] adc_sample
	logic                 m_tvalid;
	logic                 m_tready;
	logic [39:0]          m_tdata;   // [20:0] temperature_centideg, [32:21] average_code,
	                                 // [39:33] samples_in_window
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_wdata;

	// register mirror
	logic [V25_W-1:0]         v25_mv;
	logic [REF_W-1:0]         ref_mv;
	logic [SLOPE_W-1:0]       slope_cmv;
	logic signed [BASE_W-1:0] base_cdeg;

	// window mirror
	int ring [WINDOW_DEF];
	int wr_ptr;
	int fill_count;
	int window_sum;

	reading_t reading_expect_q[$];
	int       err_count   = 0;
	int       cycle_count = 0;
	bit       pace_s      = 1'b1;
	bit       pace_m      = 1'b1;

	adc_window_average_to_temperature_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[adc_window_average_to_temperature_unit] ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		err_count++;
	endtask

	function automatic reading_t predict_reading(input logic [SMP_W-1:0] sample);
		reading_t r;
		longint   mean;
		longint   mv;
		longint   slope;
		longint   diff;
		longint   t;
		if (fill_count >= WINDOW_DEF)
			window_sum -= ring[wr_ptr];
		else
			fill_count++;
		ring[wr_ptr] = int'(sample);
		window_sum += int'(sample);
		wr_ptr = (wr_ptr + 1 >= WINDOW_DEF) ? 0 : wr_ptr + 1;

		mean  = longint'(window_sum) / longint'(fill_count);
		mv    = (mean * longint'(ref_mv)) >>> SAMPLE_BITS_DEF;
		// a zero slope divides by one
		slope = (slope_cmv == '0) ? 64'sd1 : longint'(slope_cmv);
		diff  = longint'(v25_mv) - mv;
		t     = (diff * SCALE_K) / slope + longint'(base_cdeg);
		if (t > TEMP_LIMIT)
			t = TEMP_LIMIT;
		if (t < -TEMP_LIMIT)
			t = -TEMP_LIMIT;

		r.temp = t[TEMP_W-1:0];
		r.avg  = mean[SMP_W-1:0];
		r.cnt  = fill_count[CNT_W-1:0];
		return r;
	endfunction

	task automatic send_sample(input logic [SMP_W-1:0] sample);
		int gap;
		gap = pace_s ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 16'($urandom_range(0, 4095));
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, sample};
		do @(posedge clk); while (s_tready !== 1'b1);
		reading_expect_q.push_back(predict_reading(sample));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			CFG_V25:   v25_mv    = val[V25_W-1:0];
			CFG_REF:   ref_mv    = val[REF_W-1:0];
			CFG_SLOPE: slope_cmv = val[SLOPE_W-1:0];
			CFG_BASE:  base_cdeg = val[BASE_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// drop valid, drain all results, then let the pipeline go quiet
	task automatic settle_idle();
		s_tvalid <= 1'b0;
		while (reading_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// receive side: random stall per transfer, compare against oldest expectation
	initial begin : result_checker
		reading_t got;
		reading_t want;
		int       stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = pace_m ? $urandom_range(0, MAX_GAP) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid === 1'b1 && m_tready === 1'b1));
			got = m_tdata;
			if (reading_expect_q.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing expected", m_tdata));
			end else begin
				want = reading_expect_q.pop_front();
				if (got.temp !== want.temp)
					report_mismatch($sformatf("temperature_centideg got %0d expected %0d",
						got.temp, want.temp));
				if (got.avg !== want.avg)
					report_mismatch($sformatf("average_code got %0d expected %0d",
						got.avg, want.avg));
				if (got.cnt !== want.cnt)
					report_mismatch($sformatf("samples_in_window got %0d expected %0d",
						got.cnt, want.cnt));
			end
		end
	end

	// default registers: fill the window, then wrap the ring
	task automatic test_defaults_fill_wrap();
		int k;
		send_sample(12'd0);
		send_sample(12'd4095);
		for (k = 0; k < WINDOW_DEF - 2; k++)
			send_sample(SMP_W'($urandom_range(0, 4095)));
		send_sample(12'd4095);
		send_sample(12'd0);
		settle_idle();
	endtask

	// raw register extremes, zero reference, zero slope, saturation both ways
	task automatic test_register_extremes();
		write_reg(CFG_V25, CFG_DAT_W'(0));
		write_reg(CFG_REF, CFG_DAT_W'(8191));
		write_reg(CFG_SLOPE, CFG_DAT_W'(1));
		write_reg(CFG_BASE, CFG_DAT_W'(16'h4000));
		send_sample(12'd4095);
		send_sample(12'd0);
		send_sample(12'd2048);
		settle_idle();

		write_reg(CFG_V25, CFG_DAT_W'(4095));
		write_reg(CFG_REF, CFG_DAT_W'(0));
		write_reg(CFG_SLOPE, CFG_DAT_W'(0));
		write_reg(CFG_BASE, CFG_DAT_W'(16'h3FFF));
		send_sample(12'd4095);
		send_sample(12'd0);
		send_sample(12'd2048);
		settle_idle();

		write_reg(CFG_V25, CFG_DAT_W'(3300));
		write_reg(CFG_REF, CFG_DAT_W'(5000));
		write_reg(CFG_SLOPE, CFG_DAT_W'(1000));
		write_reg(CFG_BASE, CFG_DAT_W'(-10000));
		// writes past the register list must not land anywhere
		write_reg(CFG_BASE + CFG_IDX_W'(1), CFG_DAT_W'(16'h7FFF));
		write_reg(CFG_BASE + CFG_IDX_W'(4), CFG_DAT_W'(0));
		send_sample(12'd4095);
		send_sample(12'd0);
		send_sample(12'd2048);
		settle_idle();
	endtask

	// random samples in blocks; registers and pacing change between blocks
	task automatic test_random_stream();
		int               n;
		int               level;
		int               smp;
		int               base_val;
		logic [CFG_IDX_W-1:0] bad_idx;
		level = 2048;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % BLOCK_ITEMS == 0) begin
				settle_idle();
				pace_s = ($urandom_range(0, 3) != 0);
				pace_m = ($urandom_range(0, 3) != 0);
				level  = $urandom_range(0, 4095);
				write_reg(CFG_V25, CFG_DAT_W'(($urandom_range(0, 3) == 0) ?
					$urandom_range(0, 4095) : $urandom_range(0, 3300)));
				write_reg(CFG_REF, CFG_DAT_W'(($urandom_range(0, 3) == 0) ?
					$urandom_range(0, 8191) : $urandom_range(1, 5000)));
				write_reg(CFG_SLOPE, CFG_DAT_W'(($urandom_range(0, 3) == 0) ?
					$urandom_range(0, 1023) : $urandom_range(1, 1000)));
				base_val = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 32767)) :
					int'($urandom_range(0, 20000)) - 10000;
				write_reg(CFG_BASE, CFG_DAT_W'(base_val));
				if ($urandom_range(0, 3) == 0) begin
					bad_idx = CFG_BASE + CFG_IDX_W'($urandom_range(1, 4));
					write_reg(bad_idx, CFG_DAT_W'($urandom));
				end
			end
			case ($urandom_range(0, 7))
				0: smp = 0;
				1: smp = 4095;
				2, 3: begin
					// hover near one level so the mean settles
					smp = level + int'($urandom_range(0, 62)) - 31;
					if (smp < 0)
						smp = 0;
					if (smp > 4095)
						smp = 4095;
				end
				default: smp = $urandom_range(0, 4095);
			endcase
			send_sample(SMP_W'(smp));
		end
	endtask

	initial begin
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		m_tready  <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		arst_n    <= 1'b0;
		for (int i = 0; i < WINDOW_DEF; i++)
			ring[i] = 0;
		wr_ptr     = 0;
		fill_count = 0;
		window_sum = 0;
		v25_mv     = V25_RST;
		ref_mv     = REF_RST;
		slope_cmv  = SLOPE_RST;
		base_cdeg  = BASE_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults_fill_wrap();
		test_register_extremes();
		test_random_stream();
		settle_idle();

		if (err_count == 0)
			$display("[adc_window_average_to_temperature_unit] OK");
		else
			$display("[adc_window_average_to_temperature_unit] ERROR");
		$finish;
	end

endmodule
